### src/rvex_pkg.sv
// Shared types and constants for the RV32IM execute unit.
package rvex_pkg;

  localparam int XLEN       = 32;
  localparam int DIV_STAGES = XLEN;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_AMO    = 7'h2f;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] F7_MULDIV  = 7'h01;

  // funct3 codes of the M extension
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  // funct3 codes of branches
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // funct3 codes of OP / OP-IMM
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Everything an item carries down the pipe besides the divider data
  typedef struct packed {
    logic [XLEN-1:0]   alu_result;
    logic [XLEN-1:0]   amo_addr;
    logic              redirect;
    logic [XLEN-1:0]   jump_target;
    logic              exc_out;
    logic [XLEN-1:0]   tval_out;
    logic              is_md;
    logic [2:0]        f3;
    logic              neg_q;
    logic              neg_r;
    logic              div_zero;
    logic [XLEN-1:0]   dividend;
    logic [2*XLEN-1:0] product;
  } rvex_meta_t;

endpackage

### src/rvex_if.sv
// Valid/ready channels for instructions in and results out.
interface rvex_in_if import rvex_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [XLEN-1:0] insn;
  logic [XLEN-1:0] pc;
  logic [XLEN-1:0] rs1_val;
  logic [XLEN-1:0] rs2_val;
  logic [XLEN-1:0] immediate;
  logic            exc_in;
  logic [XLEN-1:0] tval_in;

  modport source (output valid, insn, pc, rs1_val, rs2_val, immediate, exc_in, tval_in,
                  input ready);
  modport sink   (input valid, insn, pc, rs1_val, rs2_val, immediate, exc_in, tval_in,
                  output ready);
endinterface

interface rvex_out_if import rvex_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [XLEN-1:0] alu_result;
  logic [XLEN-1:0] amo_addr;
  logic            redirect;
  logic [XLEN-1:0] jump_target;
  logic            exc_out;
  logic [XLEN-1:0] tval_out;

  modport source (output valid, alu_result, amo_addr, redirect, jump_target, exc_out,
                  tval_out, input ready);
  modport sink   (input valid, alu_result, amo_addr, redirect, jump_target, exc_out,
                  tval_out, output ready);
endinterface

### src/rv32im_execute_unit_top.sv
// RV32IM execute unit: a fixed pipeline, one instruction per cycle while results are taken.
//
// One instruction beat is accepted every cycle the pipe is not held, and each result beat
// leaves after one decode/ALU/multiply stage, 32 one-bit divider stages and one result stage,
// in order. Every instruction, divide or not, flows through the same stages, so the
// rate is one beat per clock; the whole pipe holds when the result beat is not taken.
module rv32im_execute_unit_top import rvex_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  rvex_in_if.sink       in_ch,
  rvex_out_if.source    out_ch
);

  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---- stage 0: decode, ALU, branch, multiply, divider setup ----
  logic [6:0]      op;
  logic [2:0]      f3;
  logic            bit30;
  logic [XLEN-1:0] a, b, opb;
  logic            take;
  logic [XLEN-1:0] target;
  logic            is_md;
  logic            sgn_a, sgn_b;
  logic [XLEN:0]   ma, mb;
  logic [2*XLEN+1:0] prod_full;
  logic [XLEN-1:0] da, db;
  rvex_meta_t      meta0;

  assign op    = in_ch.insn[6:0];
  assign f3    = in_ch.insn[14:12];
  assign bit30 = in_ch.insn[30];
  assign a     = in_ch.rs1_val;
  assign b     = in_ch.rs2_val;
  assign opb   = (op == OPC_OPIMM) ? in_ch.immediate : b;
  assign is_md = (op == OPC_OP) && (in_ch.insn[31:25] == F7_MULDIV);

  // multiply: operands sign-extended per variant
  assign sgn_a     = (f3 == F3_MULH) || (f3 == F3_MULHSU);
  assign sgn_b     = (f3 == F3_MULH);
  assign ma        = {sgn_a & a[XLEN-1], a};
  assign mb        = {sgn_b & b[XLEN-1], b};
  assign prod_full = $signed(ma) * $signed(mb);

  // divider operands: magnitudes for signed ops
  assign da = ((f3 == F3_DIV || f3 == F3_REM) && a[XLEN-1]) ? -a : a;
  assign db = ((f3 == F3_DIV || f3 == F3_REM) && b[XLEN-1]) ? -b : b;

  always_comb begin
    meta0          = '0;
    take           = 1'b0;
    target         = '0;
    meta0.f3       = f3;
    meta0.product  = prod_full[2*XLEN-1:0];
    meta0.dividend = a;
    meta0.div_zero = (b == '0);
    meta0.neg_q    = (f3 == F3_DIV) && (a[XLEN-1] ^ b[XLEN-1]);
    meta0.neg_r    = (f3 == F3_REM) && a[XLEN-1];
    if (in_ch.exc_in) begin
      meta0.exc_out  = 1'b1;
      meta0.tval_out = in_ch.tval_in;
    end else begin
      unique case (op) inside
        OPC_LUI:   meta0.alu_result = in_ch.immediate;
        OPC_AUIPC: meta0.alu_result = in_ch.pc + in_ch.immediate;
        OPC_LOAD, OPC_STORE: meta0.alu_result = a + in_ch.immediate;
        OPC_AMO:   meta0.amo_addr = a;
        OPC_JAL: begin
          meta0.alu_result = in_ch.pc + XLEN'(4);
          target           = in_ch.pc + in_ch.immediate;
          take             = 1'b1;
        end
        OPC_JALR: begin
          meta0.alu_result = in_ch.pc + XLEN'(4);
          target           = (a + in_ch.immediate) & ~XLEN'(1);
          take             = 1'b1;
        end
        OPC_BRANCH: begin
          target = in_ch.pc + in_ch.immediate;
          case (f3)
            F3_BEQ:  take = (a == b);
            F3_BNE:  take = (a != b);
            F3_BLT:  take = ($signed(a) < $signed(b));
            F3_BGE:  take = !($signed(a) < $signed(b));
            F3_BLTU: take = (a < b);
            F3_BGEU: take = (a >= b);
            default: take = 1'b0;
          endcase
        end
        OPC_OPIMM, OPC_OP: begin
          if (is_md) begin
            meta0.is_md = 1'b1;
          end else begin
            case (f3)
              F3_ADD:  meta0.alu_result = (op == OPC_OP && bit30) ? a - opb : a + opb;
              F3_SLL:  meta0.alu_result = a << opb[4:0];
              F3_SLT:  meta0.alu_result = XLEN'($signed(a) < $signed(opb));
              F3_SLTU: meta0.alu_result = XLEN'(a < opb);
              F3_XOR:  meta0.alu_result = a ^ opb;
              F3_SRL:  meta0.alu_result = bit30 ? XLEN'($signed(a) >>> opb[4:0])
                                                : a >> opb[4:0];
              F3_OR:   meta0.alu_result = a | opb;
              default: meta0.alu_result = a & opb;
            endcase
          end
        end
        default: ;
      endcase
      // taken control transfer: misaligned target traps, else redirect
      if (take) begin
        if (target[1:0] != 2'b00) begin
          meta0.exc_out  = 1'b1;
          meta0.tval_out = target;
        end else begin
          meta0.redirect    = 1'b1;
          meta0.jump_target = target;
        end
      end
    end
  end

  // ---- pipeline registers: meta and valid travel beside the divider ----
  logic       [DIV_STAGES:0] valid_r;
  rvex_meta_t                meta_r [DIV_STAGES+1];
  logic [XLEN-1:0]           rem_r  [DIV_STAGES+1];
  logic [XLEN-1:0]           quo_r  [DIV_STAGES+1];
  logic [XLEN-1:0]           dvs_r  [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[DIV_STAGES-1:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= meta0;
      rem_r[0]  <= '0;
      quo_r[0]  <= da;
      dvs_r[0]  <= db;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        meta_r[k] <= meta_r[k-1];
      end
    end
  end

  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
    rvex_div_stage u_stage (
      .clk   (clk),
      .en    (en),
      .rem_i (rem_r[g-1]),
      .quo_i (quo_r[g-1]),
      .dvs_i (dvs_r[g-1]),
      .rem_o (rem_r[g]),
      .quo_o (quo_r[g]),
      .dvs_o (dvs_r[g])
    );
  end

  // ---- result stage: pick and sign-fix the M result ----
  rvex_meta_t      mf;
  logic [XLEN-1:0] q, r, md_res;

  assign mf = meta_r[DIV_STAGES];
  assign q  = quo_r[DIV_STAGES];
  assign r  = rem_r[DIV_STAGES];

  always_comb begin
    case (mf.f3) inside
      F3_MUL:                        md_res = mf.product[XLEN-1:0];
      F3_MULH, F3_MULHSU, F3_MULHU:  md_res = mf.product[2*XLEN-1:XLEN];
      F3_DIV:  md_res = mf.div_zero ? '1 : (mf.neg_q ? -q : q);
      F3_DIVU: md_res = q;
      F3_REM:  md_res = mf.div_zero ? mf.dividend : (mf.neg_r ? -r : r);
      default: md_res = r;
    endcase
  end

  logic [XLEN-1:0] res_r, amo_r, tgt_r, tval_r;
  logic            redir_r, exc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r   <= mf.is_md ? md_res : mf.alu_result;
      amo_r   <= mf.amo_addr;
      redir_r <= mf.redirect;
      tgt_r   <= mf.jump_target;
      exc_r   <= mf.exc_out;
      tval_r  <= mf.tval_out;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.alu_result  = res_r;
  assign out_ch.amo_addr    = amo_r;
  assign out_ch.redirect    = redir_r;
  assign out_ch.jump_target = tgt_r;
  assign out_ch.exc_out     = exc_r;
  assign out_ch.tval_out    = tval_r;

endmodule

### src/rvex_div_stage.sv
// One registered restoring-division step: one quotient bit per stage.
module rvex_div_stage import rvex_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [XLEN-1:0] rem_i,
  input  logic [XLEN-1:0] quo_i,
  input  logic [XLEN-1:0] dvs_i,
  output logic [XLEN-1:0] rem_o,
  output logic [XLEN-1:0] quo_o,
  output logic [XLEN-1:0] dvs_o
);

  logic [XLEN:0] shifted;
  logic [XLEN:0] diff;

  // shift in the next dividend bit and try to subtract
  assign shifted = {rem_i, quo_i[XLEN-1]};
  assign diff    = shifted - {1'b0, dvs_i};

  always_ff @(posedge clk) begin
    if (en) begin
      dvs_o <= dvs_i;
      if (!diff[XLEN]) begin
        rem_o <= diff[XLEN-1:0];
        quo_o <= {quo_i[XLEN-2:0], 1'b1};
      end else begin
        rem_o <= shifted[XLEN-1:0];
        quo_o <= {quo_i[XLEN-2:0], 1'b0};
      end
    end
  end

endmodule

### test/rvex_tb_if.sv
`timescale 1ns / 1ps
// Testbench constants for the RV32IM execute unit.
package rvex_tb_pkg;
  localparam int LAT_CYCLES = 34;
endpackage

### test/rvex_checker.sv
`timescale 1ns / 1ps
// Result checker for the RV32IM execute unit: watches both channels and predicts each result.
module rvex_checker import rvex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rvex_in_if.sink    in_mon,
  rvex_out_if.sink   out_mon,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic [31:0] alu_result;
    logic [31:0] amo_addr;
    logic        redirect;
    logic [31:0] jump_target;
    logic        exc_out;
    logic [31:0] tval_out;
  } ex_result_t;

  ex_result_t exp_results[$];

  function automatic logic [31:0] mul_div(logic [2:0] f3, logic [31:0] x, logic [31:0] y);
    logic signed [63:0] sp;
    logic [63:0] up;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    sx = x;
    sy = y;
    case (f3)
      F3_MUL:    begin up = x * y; return up[31:0]; end
      F3_MULH:   begin sp = 64'(sx) * 64'(sy); return sp[63:32]; end
      F3_MULHSU: begin sp = 64'(sx) * $signed({32'd0, y}); return sp[63:32]; end
      F3_MULHU:  begin up = {32'd0, x} * {32'd0, y}; return up[63:32]; end
      F3_DIV: begin
        if (y == 0) return '1;
        if (x == 32'h8000_0000 && y == '1) return x;
        return sx / sy;
      end
      F3_DIVU:   return (y == 0) ? '1 : x / y;
      F3_REM: begin
        if (y == 0) return x;
        if (x == 32'h8000_0000 && y == '1) return '0;
        return sx % sy;
      end
      default:   return (y == 0) ? x : x % y;
    endcase
  endfunction

  function automatic ex_result_t execute(logic [31:0] insn, logic [31:0] pc, logic [31:0] a,
                                         logic [31:0] b, logic [31:0] imm, logic exc,
                                         logic [31:0] tval);
    ex_result_t r;
    logic [6:0] op;
    logic [2:0] f3;
    logic taken;
    logic [31:0] target;
    r = '0;
    op = insn[6:0];
    f3 = insn[14:12];
    taken = 1'b0;
    target = '0;
    if (exc) begin
      r.exc_out = 1'b1;
      r.tval_out = tval;
      return r;
    end
    case (op) inside
      OPC_LUI:   r.alu_result = imm;
      OPC_AUIPC: r.alu_result = pc + imm;
      OPC_LOAD, OPC_STORE: r.alu_result = a + imm;
      OPC_AMO:   r.amo_addr = a;
      OPC_JAL, OPC_JALR: begin
        r.alu_result = pc + 32'd4;
        target = (op == OPC_JAL) ? pc + imm : ((a + imm) & ~32'd1);
        taken = 1'b1;
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  taken = (a == b);
          F3_BNE:  taken = (a != b);
          F3_BLT:  taken = ($signed(a) < $signed(b));
          F3_BGE:  taken = ($signed(a) >= $signed(b));
          F3_BLTU: taken = (a < b);
          F3_BGEU: taken = (a >= b);
          default: taken = 1'b0;
        endcase
        target = pc + imm;
      end
      OPC_OPIMM, OPC_OP: begin
        if (op == OPC_OP && insn[31:25] == F7_MULDIV) begin
          r.alu_result = mul_div(f3, a, b);
        end else begin
          if (op == OPC_OPIMM) b = imm;
          case (f3)
            F3_ADD:  r.alu_result = (op == OPC_OP && insn[30]) ? a - b : a + b;
            F3_SLL:  r.alu_result = a << b[4:0];
            F3_SLT:  r.alu_result = {31'd0, $signed(a) < $signed(b)};
            F3_SLTU: r.alu_result = {31'd0, a < b};
            F3_XOR:  r.alu_result = a ^ b;
            F3_SRL:  r.alu_result = insn[30] ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   r.alu_result = a | b;
            default: r.alu_result = a & b;
          endcase
        end
      end
      default: ;
    endcase
    if (taken) begin
      if (target[1:0] != 2'b00) begin
        r.exc_out = 1'b1;
        r.tval_out = target;
      end else begin
        r.redirect = 1'b1;
        r.jump_target = target;
      end
    end
    return r;
  endfunction

  assign pending = exp_results.size();

  // predict on each accepted instruction beat, compare on each result beat
  always @(posedge clk) begin
    ex_result_t want;
    ex_result_t got;
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        exp_results.push_back(execute(in_mon.insn, in_mon.pc, in_mon.rs1_val, in_mon.rs2_val,
                                      in_mon.immediate, in_mon.exc_in, in_mon.tval_in));
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.alu_result, out_mon.amo_addr, out_mon.redirect, out_mon.jump_target,
                out_mon.exc_out, out_mon.tval_out};
        if (exp_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = exp_results.pop_front();
          if (got !== want) begin
            $display({"%0t: mismatch alu %h/%h amo %h/%h redir %b/%b tgt %h/%h",
                      " exc %b/%b tval %h/%h"},
                     $time, want.alu_result, got.alu_result, want.amo_addr, got.amo_addr,
                     want.redirect, got.redirect, want.jump_target, got.jump_target,
                     want.exc_out, got.exc_out, want.tval_out, got.tval_out);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the RV32IM execute unit testbench.
module tb;
  import rvex_pkg::*;
  import rvex_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   idle_cycles = 0;
  int   beat_idx;
  logic hold_recv;
  logic quiet;

  rvex_in_if  in_ch ();
  rvex_out_if out_ch ();

  rv32im_execute_unit_top dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  rvex_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                    .errors(errors), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls, a long hold-off, and a quiet stretch
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_recv) out_ch.ready <= 1'b0;
      else out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 21);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] pick_val();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'hffff_ffff;
      2: return 32'd0;
      3: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] pick_opcode();
    case ($urandom_range(11))
      0: return OPC_LUI;
      1: return OPC_AUIPC;
      2: return OPC_LOAD;
      3: return OPC_STORE;
      4: return OPC_AMO;
      5: return OPC_JAL;
      6: return OPC_JALR;
      7: return OPC_BRANCH;
      8: return OPC_OPIMM;
      9: return OPC_OP;
      10: return OPC_OP;
      default: return 7'($urandom);
    endcase
  endfunction

  // drive one instruction beat and wait for its acceptance
  task automatic send_insn(logic [31:0] insn, logic [31:0] pc, logic [31:0] a, logic [31:0] b,
                           logic [31:0] imm, logic exc, logic [31:0] tval);
    while (!quiet && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.insn <= insn;
    in_ch.pc <= pc;
    in_ch.rs1_val <= a;
    in_ch.rs2_val <= b;
    in_ch.immediate <= imm;
    in_ch.exc_in <= exc;
    in_ch.tval_in <= tval;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    beat_idx++;
  endtask

  task automatic send_random();
    logic [31:0] insn;
    insn = $urandom;
    insn[6:0] = pick_opcode();
    if (insn[6:0] == OPC_OP && $urandom_range(1)) insn[31:25] = F7_MULDIV;
    else if ($urandom_range(1)) insn[31:25] = {1'b0, $urandom_range(1) ? 1'b1 : 1'b0, 5'd0};
    send_insn(insn, $urandom_range(3) == 0 ? $urandom : ($urandom & 32'hffff_fffc),
              pick_val(), pick_val(), $urandom_range(1) ? pick_val() : 32'($urandom_range(64)),
              $urandom_range(15) == 0, $urandom);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [6:0] ops [10];
    ops = '{OPC_LUI, OPC_AUIPC, OPC_LOAD, OPC_STORE, OPC_AMO, OPC_JAL, OPC_JALR,
            OPC_BRANCH, OPC_OPIMM, OPC_OP};
    rst_n = 1'b0;
    hold_recv = 1'b0;
    quiet = 1'b0;
    beat_idx = 0;
    in_ch.valid = 1'b0;
    in_ch.insn = '0;
    in_ch.pc = '0;
    in_ch.rs1_val = '0;
    in_ch.rs2_val = '0;
    in_ch.immediate = '0;
    in_ch.exc_in = 1'b0;
    in_ch.tval_in = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every opcode, extremes, divide corner cases, misaligned jumps, exceptions
    foreach (ops[i]) send_insn({25'd0, ops[i]}, 32'h100, 32'hffff_ffff, 32'h8000_0000,
                               32'h8, 1'b0, '0);
    send_insn({F7_MULDIV, 10'd0, F3_DIV, 5'd0, OPC_OP}, 0, 32'h8000_0000, 32'hffff_ffff, 0,
              1'b0, 0);
    send_insn({F7_MULDIV, 10'd0, F3_REM, 5'd0, OPC_OP}, 0, 32'h8000_0000, 32'hffff_ffff, 0,
              1'b0, 0);
    send_insn({F7_MULDIV, 10'd0, F3_DIV, 5'd0, OPC_OP}, 0, 32'd7, 32'd0, 0, 1'b0, 0);
    send_insn({F7_MULDIV, 10'd0, F3_REMU, 5'd0, OPC_OP}, 0, 32'd7, 32'd0, 0, 1'b0, 0);
    send_insn({7'h20, 10'd0, F3_SRL, 5'd0, OPC_OP}, 0, 32'h8000_0000, 32'd63, 0, 1'b0, 0);
    send_insn({25'd0, OPC_JAL}, 32'h100, 0, 0, 32'h2, 1'b0, 0);
    send_insn({25'd0, OPC_JALR}, 32'h100, 32'h3, 0, 32'h0, 1'b0, 0);
    send_insn({17'd0, F3_BEQ, 5'd0, OPC_BRANCH}, 32'h100, 5, 5, 32'h6, 1'b0, 0);
    send_insn({17'd0, 3'd2, 5'd0, OPC_BRANCH}, 32'h100, 5, 5, 32'h8, 1'b0, 0);
    send_insn({25'd0, OPC_JAL}, 32'hffff_fffc, 0, 0, 32'h8, 1'b1, 32'hffff_ffff);
    send_insn('1, '1, '1, '1, '1, 1'b0, '1);
    drain();

    // bulk random traffic, with a quiet stretch, a receiver hold-off and a sender pause until everything has drained
    while (beat_idx < 930) begin
      if (beat_idx == 300) quiet = 1'b1;
      if (beat_idx == 420) quiet = 1'b0;
      if (beat_idx == 600) begin
        hold_recv = 1'b1;
        fork
          begin repeat (150) @(negedge clk); hold_recv = 1'b0; end
        join_none
      end
      if (beat_idx == 750) drain();
      send_random();
    end
    drain();
    repeat (LAT_CYCLES + 10) @(negedge clk);
    if (errors == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
src/rvex_pkg.sv
src/rvex_if.sv
src/rvex_div_stage.sv
src/rv32im_execute_unit_top.sv
test/rvex_tb_if.sv
test/rvex_checker.sv
test/tb.sv
